// ===== design/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg: shared types and constants for the sorted-array priority queue
// Holds the request and result formats, the operation codes and the default
// queue depth used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int VALUE_W       = 32;
    localparam int CMD_W         = 2;
    localparam int COUNT_W       = 4;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] push_value;
    } t_request;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic signed [VALUE_W-1:0] head_value;
        logic [COUNT_W-1:0]        entry_count;
        logic                      is_empty;
        logic                      is_full;
        logic                      rejected;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // apply the captured request to the array
    } t_dp_cmd;

endpackage

// ===== design/sapq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sapq_ctrl: request sequencer
// Takes a request when idle, moves to its execute state and raises the
// result strobe in the following cycle.
// ----------------------------------------------------------------------------
module sapq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_valid,
    output sapq_pkg::t_dp_cmd o_dp_cmd
);
    import sapq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    assign busy          = (r_state == S_EXEC);
    assign o_valid       = r_done;
    assign o_dp_cmd.load = start && (r_state == S_IDLE);
    assign o_dp_cmd.exec = (r_state == S_EXEC);

endmodule

// ===== design/sapq_datapath.sv =====
// ----------------------------------------------------------------------------
// sapq_datapath: compare-and-shift array and result register
// Each slot compares its own entry with the pushed value, so an insertion or
// a removal updates every slot of the array together.
// ----------------------------------------------------------------------------
module sapq_datapath #(
    parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sapq_pkg::t_dp_cmd  i_dp_cmd,
    input  sapq_pkg::t_request i_request,
    output sapq_pkg::t_result  o_result
);
    import sapq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_request                  r_req;
    logic signed [VALUE_W-1:0] r_entry [DEPTH];
    logic signed [VALUE_W-1:0] n_entry [DEPTH];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    t_result                   r_result;
    t_result                   n_result;

    logic [DEPTH-1:0] keep;      // slot holds a valid entry <= pushed value
    logic             is_push;
    logic             is_pop;
    logic             full;
    logic             empty;
    logic             push_ok;
    logic             pop_ok;

    assign is_push = (r_req.cmd == CMD_PUSH);
    assign is_pop  = (r_req.cmd == CMD_POP);
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign push_ok = is_push && !full;
    assign pop_ok  = is_pop && !empty;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            keep[i] = (CW'(i) < r_count) && (r_entry[i] <= r_req.push_value);
        end
    end

    // Next array contents. A push keeps the prefix of smaller-or-equal
    // entries, drops the value in at the first slot past them and shifts
    // the rest up by one. A pop shifts everything down by one.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entry[i] = r_entry[i];
            if (push_ok) begin
                if (keep[i]) begin
                    n_entry[i] = r_entry[i];
                end else if (i == 0) begin
                    n_entry[i] = r_req.push_value;
                end else if (keep[i-1]) begin
                    n_entry[i] = r_req.push_value;
                end else begin
                    n_entry[i] = r_entry[i-1];
                end
            end else if (pop_ok && (i < DEPTH - 1)) begin
                n_entry[i] = r_entry[i+1];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_result.popped_value = pop_ok ? r_entry[0] : '0;
        n_result.head_value   = (n_count != '0) ? n_entry[0] : '0;
        n_result.entry_count  = COUNT_W'(n_count);
        n_result.is_empty     = (n_count == '0);
        n_result.is_full      = (n_count == CW'(DEPTH));
        n_result.rejected     = (is_push && full) || (is_pop && empty);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_req <= i_request;
        end
        if (i_dp_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entry[i] <= n_entry[i];
            end
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// ===== design/sorted_array_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core: bounded min-priority queue
// A taken request moves the controller into its execute state, and the
// result strobe is registered from that state. No new request is taken while
// busy; busy is high for the single cycle in which the compare-and-shift
// array updates. Results are shown for one cycle and cannot be stalled by the receiver.
// Reset (synchronous, active low) empties the queue; stored slots are not
// cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_core #(
    parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sapq_pkg::t_request i_request,
    output logic               o_valid,
    output sapq_pkg::t_result  o_result
);
    import sapq_pkg::*;

    // The controller decides when a request is captured and when it is
    // applied; the datapath owns the sorted array, the entry count and the
    // registered result. The two meet only through the command struct.
    t_dp_cmd dp_cmd;

    sapq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_dp_cmd (dp_cmd)
    );

    // The array keeps entries in ascending order. A push places the value
    // after any equal entries, so equal values leave in arrival order; a
    // push while full or a pop while empty leaves everything unchanged and
    // sets the rejected flag in the result.
    sapq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dp_cmd  (dp_cmd),
        .i_request (i_request),
        .o_result  (o_result)
    );

    // The execute state always returns to idle, so busy never stays high.
    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // An accepted request always moves the controller into execution.
    a_start_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start execution");

    // Every result strobe follows an execution cycle.
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding execution");

    // The queue cannot be both empty and full.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.is_empty && o_result.is_full))
        else $error("result reports empty and full together");

endmodule
